// ----- rtl/slbd_pkg.sv -----
// ----------------------------------------------------------------------------
// slbd_pkg
// Shared constants, codes and controller/datapath interface types of the
// sonar line box decimator.
// ----------------------------------------------------------------------------
package slbd_pkg;

  localparam int MAX_BINS    = 4096;
  localparam int NUM_SOURCES = 8;
  localparam int MAX_FACTOR  = 1024;
  localparam int SAMPLE_BITS = 24;
  localparam int MAX_OUT     = 64;

  localparam int SRC_W    = 3;
  localparam int BIN_W    = 12;
  localparam int SUM_W    = SAMPLE_BITS + 20;
  localparam int PART_W   = SAMPLE_BITS + 10;
  localparam int POS_W    = 23;
  localparam int TIME_W   = 62;
  localparam int TSUM_W   = 64;
  localparam int RATE_W   = 27;
  localparam int FAC_W    = 11;
  localparam int OFF_W    = 10;
  localparam int LINES_W  = 11;
  localparam int STORE_W  = 13;
  localparam int CNT_W    = 7;
  localparam int ADDR_W   = SRC_W + BIN_W;
  localparam int PROD_W   = 21;
  localparam int DIV_W    = 64;
  localparam int DREM_W   = 21;
  localparam int STEP_W   = 7;
  localparam int CIDX_W   = 2;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_RANGE = 2'd1,
    CFG_TRACK = 2'd2,
    CFG_RATE  = 2'd3
  } cfg_idx_t;

  // Divider operations
  typedef enum logic [1:0] {
    DIV_POS  = 2'd0,
    DIV_RATE = 2'd1,
    DIV_MEAN = 2'd2,
    DIV_AVG  = 2'd3
  } div_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    clr_step;
    logic    clr_src;
    logic    take;
    logic    div_start;
    div_op_t div_op;
    logic    pos_load;
    logic    rate_load;
    logic    mean_load;
    logic    part_add;
    logic    bin_write;
    logic    ram_rd;
    logic    pos_step;
    logic    eol_update;
    logic    loop_step;
    logic    out_load;
    logic    out_pass;
    logic    out_loop;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic pass_mode;
    logic dirty;
    logic mid_emit;
    logic need_mean;
    logic eol;
    logic emit_now;
    logic loop_more;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/slbd_ram.sv -----
// ----------------------------------------------------------------------------
// slbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/slbd_div.sv -----
// ----------------------------------------------------------------------------
// slbd_div
// Shared restoring divider, one quotient bit per cycle. The dividend comes
// left aligned; steps gives the number of significant dividend bits.
// ----------------------------------------------------------------------------
module slbd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [slbd_pkg::DIV_W-1:0]  dividend,
  input  logic [slbd_pkg::DREM_W-1:0] divisor,
  input  logic [slbd_pkg::STEP_W-1:0] steps,
  output logic                       done,
  output logic [slbd_pkg::DIV_W-1:0]  quotient,
  output logic [slbd_pkg::DREM_W-1:0] remainder
);
  import slbd_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DREM_W-1:0] rem_r;
  logic [DREM_W-1:0] dvs_r;
  logic [DREM_W:0]   trial;
  logic              ge;
  logic [DREM_W-1:0] rem_nxt;
  logic [DIV_W-1:0]  quo_nxt;

  // one trial subtract per cycle
  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? DREM_W'(trial - {1'b0, dvs_r}) : trial[DREM_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/slbd_dp.sv -----
// ----------------------------------------------------------------------------
// slbd_dp
// Datapath: configuration, line position, bin store, per-source line state,
// shared divider and the result register.
// ----------------------------------------------------------------------------
module slbd_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [slbd_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [slbd_pkg::RATE_W-1:0]        cfg_data,
  input  logic [slbd_pkg::SRC_W-1:0]         in_source_id,
  input  logic signed [slbd_pkg::SAMPLE_BITS-1:0] in_sample_value,
  input  logic [slbd_pkg::TIME_W-1:0]        in_line_time,
  input  logic                               in_end_of_line,
  input  slbd_pkg::cmd_t                     cmd,
  output slbd_pkg::sts_t                     sts,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [slbd_pkg::SRC_W-1:0]         out_source,
  output logic signed [slbd_pkg::SAMPLE_BITS-1:0] out_value,
  output logic [slbd_pkg::TIME_W-1:0]        out_time,
  output logic [slbd_pkg::RATE_W-1:0]        out_rate,
  output logic [slbd_pkg::BIN_W-1:0]         out_bin_number,
  output logic                               out_line_done
);
  import slbd_pkg::*;

  // configuration
  logic              mode_r;
  logic [FAC_W-1:0]  range_r;
  logic [FAC_W-1:0]  track_r;
  logic [RATE_W-1:0] irate_r;
  logic              dirty_r;
  logic [FAC_W-1:0]  fac;
  logic              fac_ok;

  // current transaction
  logic [SRC_W-1:0]       it_src_r;
  logic [SAMPLE_BITS-1:0] it_smp_r;
  logic [TIME_W-1:0]      it_time_r;
  logic                   it_eol_r;

  // line position and bin accumulation
  logic [POS_W-1:0]  pos_r;
  logic [OFF_W-1:0]  off_r;
  logic [POS_W-1:0]  kq_r;
  logic [PART_W-1:0] partial_r;
  logic [RATE_W-1:0] rate_r;
  logic [TIME_W-1:0] mean_r;
  logic [PROD_W-1:0] prod_r;
  logic              neg_r;

  // per-source line state
  logic [LINES_W-1:0] lines_r [NUM_SOURCES];
  logic [TSUM_W-1:0]  tsum_r  [NUM_SOURCES];
  logic [STORE_W-1:0] stored_r [NUM_SOURCES];

  // emission loop
  logic [STORE_W-1:0] j_r;
  logic [STORE_W-1:0] total_r;
  logic [CNT_W-1:0]   n_r;

  // clearing sweep
  logic [ADDR_W-1:0] clr_addr_r;
  logic              clr_full_r;

  // output register
  logic                   out_valid_r;
  logic [SRC_W-1:0]       o_src_r;
  logic [SAMPLE_BITS-1:0] o_val_r;
  logic [TIME_W-1:0]      o_time_r;
  logic [RATE_W-1:0]      o_rate_r;
  logic [BIN_W-1:0]       o_bin_r;
  logic                   o_done_r;

  // derived values
  logic               bnd;
  logic               kq_in;
  logic               last_line;
  logic               mid_emit;
  logic [POS_W:0]     k_end;
  logic [STORE_W-1:0] c_bins;
  logic [STORE_W-1:0] stored_nxt;
  logic [LINES_W-1:0] lines_nxt;
  logic [TSUM_W-1:0]  tsum_nxt;
  logic               emit_now;
  logic [BIN_W-1:0]   e_bin;
  logic               out_free;
  logic               emit_done;

  // ram
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SUM_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SUM_W-1:0]  ram_rdata;
  logic [SUM_W-1:0]  mag;

  // divider
  logic [DIV_W-1:0]  div_a;
  logic [DREM_W-1:0] div_b;
  logic [STEP_W-1:0] div_n;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;
  logic [DREM_W-1:0] div_rm;
  logic [SUM_W-1:0]  avg_q;
  logic [SAMPLE_BITS-1:0] avg_val;

  assign fac    = cfg_data[FAC_W-1:0];
  assign fac_ok = (fac >= FAC_W'(1)) && (fac <= FAC_W'(MAX_FACTOR));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      range_r <= FAC_W'(1);
      track_r <= FAC_W'(1);
      irate_r <= '0;
      dirty_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MODE:  mode_r <= cfg_data[0];
          CFG_RANGE: begin
            if (fac_ok) range_r <= fac;
            dirty_r <= 1'b1;
          end
          CFG_TRACK: if (fac_ok) track_r <= fac;
          CFG_RATE:  begin
            irate_r <= cfg_data;
            dirty_r <= 1'b1;
          end
        endcase
      end else if (cmd.rate_load) begin
        dirty_r <= 1'b0;
      end
    end
  end

  // bin divisor, refreshed every cycle from stable factors
  always_ff @(posedge clk) begin
    prod_r <= {10'b0, range_r} * {10'b0, track_r};
  end

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      it_src_r  <= in_source_id;
      it_smp_r  <= in_sample_value;
      it_time_r <= in_line_time;
      it_eol_r  <= in_end_of_line;
    end
  end

  // position and bin decisions
  always_comb begin
    bnd       = ({1'b0, off_r} == (range_r - FAC_W'(1)));
    kq_in     = (kq_r[POS_W-1:BIN_W] == '0);
    last_line = (({1'b0, lines_r[it_src_r]} + (LINES_W+1)'(1)) >= {1'b0, track_r});
    mid_emit  = bnd && !it_eol_r && last_line && kq_in && (kq_r != '0);
    k_end     = {1'b0, kq_r} + {{POS_W{1'b0}}, bnd};
    c_bins    = (k_end >= (POS_W+1)'(MAX_BINS)) ? STORE_W'(MAX_BINS) : k_end[STORE_W-1:0];
    stored_nxt = (c_bins > stored_r[it_src_r]) ? c_bins : stored_r[it_src_r];
    lines_nxt = (&lines_r[it_src_r]) ? lines_r[it_src_r] : lines_r[it_src_r] + 1'b1;
    tsum_nxt  = tsum_r[it_src_r] + {2'b0, it_time_r};
    emit_now  = ({1'b0, lines_nxt} >= {1'b0, track_r});
    if (kq_r == '0) begin
      e_bin = '0;
    end else if (kq_r > POS_W'(MAX_BINS)) begin
      e_bin = BIN_W'(MAX_BINS - 1);
    end else begin
      e_bin = BIN_W'(kq_r - 1'b1);
    end
  end

  // position, partial sum, divided values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      off_r     <= '0;
      kq_r      <= '0;
      partial_r <= '0;
      rate_r    <= '0;
    end else begin
      if (cmd.pos_load) begin
        kq_r  <= div_q[POS_W-1:0];
        off_r <= div_rm[OFF_W-1:0];
      end
      if (cmd.rate_load) begin
        rate_r <= div_q[RATE_W-1:0];
      end
      if (cmd.part_add) begin
        partial_r <= partial_r + {{(PART_W-SAMPLE_BITS){it_smp_r[SAMPLE_BITS-1]}}, it_smp_r};
      end
      if (cmd.bin_write && bnd) begin
        partial_r <= '0;
      end
      // advance the position within the line
      if (cmd.pos_step) begin
        if (it_eol_r || (&pos_r)) begin
          pos_r <= '0;
          off_r <= '0;
          kq_r  <= '0;
        end else begin
          pos_r <= pos_r + 1'b1;
          if (bnd) begin
            off_r <= '0;
            kq_r  <= kq_r + 1'b1;
          end else begin
            off_r <= off_r + 1'b1;
          end
        end
      end
      if (cmd.eol_update) begin
        pos_r     <= '0;
        off_r     <= '0;
        kq_r      <= '0;
        partial_r <= '0;
      end
    end
  end

  // per-source line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        lines_r[s]  <= '0;
        tsum_r[s]   <= '0;
        stored_r[s] <= '0;
      end
    end else if (cmd.eol_update) begin
      if (emit_now) begin
        lines_r[it_src_r]  <= '0;
        tsum_r[it_src_r]   <= '0;
        stored_r[it_src_r] <= '0;
      end else begin
        lines_r[it_src_r]  <= lines_nxt;
        tsum_r[it_src_r]   <= tsum_nxt;
        stored_r[it_src_r] <= stored_nxt;
      end
    end
  end

  // emission loop counters and mean time
  always_ff @(posedge clk) begin
    if (cmd.bin_write) begin
      j_r <= STORE_W'(kq_r[BIN_W-1:0]) - 1'b1;
    end
    if (cmd.eol_update) begin
      j_r     <= {1'b0, e_bin};
      total_r <= stored_nxt;
      n_r     <= '0;
    end
    if (cmd.loop_step) begin
      j_r <= j_r + 1'b1;
      n_r <= n_r + 1'b1;
    end
    if (cmd.mean_load) begin
      mean_r <= div_q[TIME_W-1:0];
    end
    if (cmd.div_start && (cmd.div_op == DIV_AVG)) begin
      neg_r <= ram_rdata[SUM_W-1];
    end
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_full_r <= 1'b1;
    end else if (cmd.clr_src) begin
      clr_addr_r <= {it_src_r, {BIN_W{1'b0}}};
      clr_full_r <= 1'b0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // bin store access
  always_comb begin
    ram_we    = cmd.clr_step || (cmd.bin_write && bnd && kq_in);
    ram_waddr = cmd.clr_step ? clr_addr_r : {it_src_r, kq_r[BIN_W-1:0]};
    ram_wdata = cmd.clr_step ? '0 :
                ram_rdata + {{(SUM_W-PART_W){partial_r[PART_W-1]}}, partial_r};
    ram_raddr = cmd.part_add ? {it_src_r, kq_r[BIN_W-1:0]} : {it_src_r, j_r[BIN_W-1:0]};
    mag       = ram_rdata[SUM_W-1] ? (~ram_rdata + 1'b1) : ram_rdata;
  end

  slbd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NUM_SOURCES * MAX_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.ram_rd),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // divider operand selection, dividends left aligned
  always_comb begin
    unique case (cmd.div_op)
      DIV_POS: begin
        div_a = {pos_r, {(DIV_W-POS_W){1'b0}}};
        div_b = {{(DREM_W-FAC_W){1'b0}}, range_r};
        div_n = STEP_W'(POS_W);
      end
      DIV_RATE: begin
        div_a = {irate_r, {(DIV_W-RATE_W){1'b0}}};
        div_b = {{(DREM_W-FAC_W){1'b0}}, range_r};
        div_n = STEP_W'(RATE_W);
      end
      DIV_MEAN: begin
        div_a = tsum_nxt;
        div_b = {{(DREM_W-FAC_W){1'b0}}, track_r};
        div_n = STEP_W'(DIV_W);
      end
      DIV_AVG: begin
        div_a = {mag, {(DIV_W-SUM_W){1'b0}}};
        div_b = prod_r;
        div_n = STEP_W'(SUM_W);
      end
    endcase
  end

  slbd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .steps     (div_n),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rm)
  );

  // signed, saturated bin average
  always_comb begin
    avg_q = div_q[SUM_W-1:0];
    if (!neg_r) begin
      avg_val = (avg_q > SUM_W'((1 << (SAMPLE_BITS-1)) - 1)) ?
                {1'b0, {(SAMPLE_BITS-1){1'b1}}} : avg_q[SAMPLE_BITS-1:0];
    end else begin
      avg_val = (avg_q > SUM_W'(1 << (SAMPLE_BITS-1))) ?
                {1'b1, {(SAMPLE_BITS-1){1'b0}}} : (~avg_q[SAMPLE_BITS-1:0] + 1'b1);
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign emit_done = cmd.out_loop &&
                     ((j_r == total_r - 1'b1) || (n_r == CNT_W'(MAX_OUT - 1)));

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_src_r <= it_src_r;
      if (cmd.out_pass) begin
        o_val_r  <= it_smp_r;
        o_time_r <= it_time_r;
        o_rate_r <= irate_r;
        o_bin_r  <= pos_r[BIN_W-1:0];
        o_done_r <= it_eol_r;
      end else begin
        o_val_r  <= avg_val;
        o_time_r <= mean_r;
        o_rate_r <= rate_r;
        o_bin_r  <= j_r[BIN_W-1:0];
        o_done_r <= emit_done;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_source     = o_src_r;
  assign out_value      = o_val_r;
  assign out_time       = o_time_r;
  assign out_rate       = o_rate_r;
  assign out_bin_number = o_bin_r;
  assign out_line_done  = o_done_r;

  // status to the controller
  always_comb begin
    sts.clr_last  = (&clr_addr_r[BIN_W-1:0]) && (!clr_full_r || (&clr_addr_r[ADDR_W-1:BIN_W]));
    sts.pass_mode = !mode_r || ((range_r == FAC_W'(1)) && (track_r == FAC_W'(1)));
    sts.dirty     = dirty_r;
    sts.mid_emit  = mid_emit;
    sts.need_mean = last_line && (it_eol_r || mid_emit);
    sts.eol       = it_eol_r;
    sts.emit_now  = emit_now;
    sts.loop_more = (j_r < total_r) && (n_r < CNT_W'(MAX_OUT));
    sts.div_done  = div_done;
    sts.out_free  = out_free;
  end

endmodule

// ----- rtl/slbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// slbd_ctrl
// Controller: sequences clearing, pass-through, accumulation, divisions and
// bin emission for one transaction at a time.
// ----------------------------------------------------------------------------
module slbd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  slbd_pkg::sts_t sts,
  output slbd_pkg::cmd_t cmd
);
  import slbd_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECIDE, S_PASS, S_DPOS, S_WPOS, S_DRATE, S_WRATE,
    S_SAMPLE, S_ADD, S_DMEAN, S_WMEAN, S_AVGRD, S_AVGDIV, S_AVGWAIT,
    S_AVGOUT, S_POSUPD, S_EOL, S_LOOP
  } state_t;

  state_t state_r, state_nxt;
  logic   loop_r, loop_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    loop_nxt  = loop_r;
    cmd       = '0;
    cmd.div_op = DIV_POS;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (sts.pass_mode) state_nxt = S_PASS;
        else if (sts.dirty)         state_nxt = S_DPOS;
        else                        state_nxt = S_SAMPLE;
      end
      S_PASS: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_pass = 1'b1;
          cmd.pos_step = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DPOS: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_POS;
        state_nxt     = S_WPOS;
      end
      S_WPOS: begin
        if (sts.div_done) begin
          cmd.pos_load = 1'b1;
          state_nxt    = S_DRATE;
        end
      end
      S_DRATE: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_RATE;
        state_nxt     = S_WRATE;
      end
      S_WRATE: begin
        if (sts.div_done) begin
          cmd.rate_load = 1'b1;
          state_nxt     = S_SAMPLE;
        end
      end
      S_SAMPLE: begin
        cmd.part_add = 1'b1;
        cmd.ram_rd   = 1'b1;
        state_nxt    = S_ADD;
      end
      S_ADD: begin
        cmd.bin_write = 1'b1;
        loop_nxt      = 1'b0;
        priority if (sts.need_mean) state_nxt = S_DMEAN;
        else if (sts.eol)           state_nxt = S_EOL;
        else                        state_nxt = S_POSUPD;
      end
      S_DMEAN: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_MEAN;
        state_nxt     = S_WMEAN;
      end
      S_WMEAN: begin
        if (sts.div_done) begin
          cmd.mean_load = 1'b1;
          priority if (sts.eol)    state_nxt = S_EOL;
          else if (sts.mid_emit)   state_nxt = S_AVGRD;
          else                     state_nxt = S_POSUPD;
        end
      end
      S_AVGRD: begin
        cmd.ram_rd = 1'b1;
        state_nxt  = S_AVGDIV;
      end
      S_AVGDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_AVG;
        state_nxt     = S_AVGWAIT;
      end
      S_AVGWAIT: begin
        cmd.div_op = DIV_AVG;
        if (sts.div_done) state_nxt = S_AVGOUT;
      end
      S_AVGOUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_loop = loop_r;
          if (loop_r) begin
            cmd.loop_step = 1'b1;
            state_nxt     = S_LOOP;
          end else begin
            state_nxt = S_POSUPD;
          end
        end
      end
      S_POSUPD: begin
        cmd.pos_step = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_EOL: begin
        cmd.eol_update = 1'b1;
        if (sts.emit_now) begin
          loop_nxt  = 1'b1;
          state_nxt = S_LOOP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LOOP: begin
        if (sts.loop_more) begin
          state_nxt = S_AVGRD;
        end else begin
          cmd.clr_src = 1'b1;
          state_nxt   = S_CLEAR;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      loop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      loop_r  <= loop_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ----- rtl/sonar_line_box_decimator_top.sv -----
// ----------------------------------------------------------------------------
// sonar_line_box_decimator_top
// Box-average decimator for sonar line samples, one sample per transaction.
// In averaging mode range_factor samples form a bin and track_factor lines of
// one source form an output line; each bin leaves as sum / (range * track)
// truncated toward zero and saturated, with the mean line time. A shared
// one-bit-per-cycle divider computes the mean time and each emitted bin, and
// the first averaging sample after a range_factor or input_rate write also
// waits for it to recompute the position and rate. The bin store is a
// 32768 x 44 RAM: after reset it is cleared whole, and after each output line
// the source's 4096 bins are cleared, during which no sample is taken. A
// waiting result holds the block once the next result is ready to load, and
// the input stays stalled until it leaves.
// ----------------------------------------------------------------------------
module sonar_line_box_decimator_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [slbd_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [slbd_pkg::RATE_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [slbd_pkg::SRC_W-1:0]         in_source_id,
  input  logic signed [slbd_pkg::SAMPLE_BITS-1:0] in_sample_value,
  input  logic [slbd_pkg::TIME_W-1:0]        in_line_time,
  input  logic                               in_end_of_line,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [slbd_pkg::SRC_W-1:0]         out_source,
  output logic signed [slbd_pkg::SAMPLE_BITS-1:0] out_value,
  output logic [slbd_pkg::TIME_W-1:0]        out_time,
  output logic [slbd_pkg::RATE_W-1:0]        out_rate,
  output logic [slbd_pkg::BIN_W-1:0]         out_bin_number,
  output logic                               out_line_done
);
  import slbd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  slbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  slbd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_source_id    (in_source_id),
    .in_sample_value (in_sample_value),
    .in_line_time    (in_line_time),
    .in_end_of_line  (in_end_of_line),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_source      (out_source),
    .out_value       (out_value),
    .out_time        (out_time),
    .out_rate        (out_rate),
    .out_bin_number  (out_bin_number),
    .out_line_done   (out_line_done)
  );

endmodule

// ----- rtl/slbd_checker.sv -----
// ----------------------------------------------------------------------------
// slbd_checker
// Port-level checks of the sonar line box decimator, bound to the top level.
// ----------------------------------------------------------------------------
module slbd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [slbd_pkg::SAMPLE_BITS-1:0] out_value,
  input logic [slbd_pkg::TIME_W-1:0]        out_time,
  input logic [slbd_pkg::BIN_W-1:0]         out_bin_number
);

  // store clearing holds the input off right after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // no result leaves right after reset
  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // hold a stalled result
  a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_value) && $stable(out_time) &&
                               $stable(out_bin_number))
    else $error("stalled result changed");

endmodule

bind sonar_line_box_decimator_top slbd_checker u_slbd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_value      (out_value),
  .out_time       (out_time),
  .out_bin_number (out_bin_number)
);
